>>> rtl/pipc_pkg.sv
// pipc_pkg: shared constants and types for the point-in-polygon crossing block
// no dependencies; imported by every rtl module of the block

package pipc_pkg;

    // default coordinate width, signed two's complement
    localparam int COORD_W_DEF = 24;

    // vertex counter
    localparam int          COUNT_W   = 16;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // configuration register indexes
    localparam logic REG_QUERY_X = 1'b0;
    localparam logic REG_QUERY_Y = 1'b1;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // per-vertex control carried from front to back
    typedef struct packed {
        logic               first;   // first vertex of a polygon, parity restarts
        logic               last;    // closing vertex, a result goes out
        logic [COUNT_W-1:0] count;   // vertices seen including this one
    } t_ctl;

endpackage

>>> rtl/pipc_front.sv
// pipc_front: query registers, polygon vertex tracking and edge classification
// depends on pipc_pkg; feeds edge operand records into pipc_queue

module pipc_front
    import pipc_pkg::*;
#(
    parameter int COORD_W = COORD_W_DEF,
    parameter int EDGE_W  = 4 * (COORD_W + 1) + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration writes
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [COORD_W-1:0] i_cfg_data,
    // vertex transaction
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [COORD_W-1:0] i_vertex_x,
    input  logic [COORD_W-1:0] i_vertex_y,
    input  logic               i_last_vertex,
    // queue side
    input  logic               i_q_full,
    output logic               o_push,
    output t_ctl               o_ctl,
    output logic [EDGE_W-1:0]  o_main,
    output logic [EDGE_W-1:0]  o_close
);

    logic signed [COORD_W-1:0] r_query_x;
    logic signed [COORD_W-1:0] r_query_y;
    logic signed [COORD_W-1:0] r_first_x;
    logic signed [COORD_W-1:0] r_first_y;
    logic signed [COORD_W-1:0] r_prev_x;
    logic signed [COORD_W-1:0] r_prev_y;
    logic [COUNT_W-1:0]        r_seen;
    logic [COUNT_W-1:0]        n_seen;

    logic                      seen_zero;
    logic                      accept;
    logic [COUNT_W-1:0]        count_inc;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] fx;
    logic signed [COORD_W-1:0] fy;

    // edge operands: a = start point, b = end point
    logic signed [COORD_W:0] m_dx, m_d, m_ex, m_ey;
    logic signed [COORD_W:0] c_dx, c_d, c_ex, c_ey;
    logic                    m_straddle;
    logic                    c_straddle;

    assign vx        = $signed(i_vertex_x);
    assign vy        = $signed(i_vertex_y);
    assign seen_zero = (r_seen == '0);
    assign accept    = i_in_valid && o_in_ready;
    assign o_in_ready = !i_q_full;
    assign o_push    = accept;

    // first vertex of a new polygon closes onto itself
    assign fx = seen_zero ? vx : r_first_x;
    assign fy = seen_zero ? vy : r_first_y;

    assign count_inc = (r_seen == COUNT_MAX) ? COUNT_MAX : r_seen + 1'b1;
    assign n_seen    = i_last_vertex ? '0 : count_inc;

    // main edge runs from the new vertex to the previous one
    always_comb begin
        m_dx = {r_query_x[COORD_W-1], r_query_x} - {vx[COORD_W-1], vx};
        m_d  = {r_prev_y[COORD_W-1], r_prev_y} - {vy[COORD_W-1], vy};
        m_ex = {r_prev_x[COORD_W-1], r_prev_x} - {vx[COORD_W-1], vx};
        m_ey = {r_query_y[COORD_W-1], r_query_y} - {vy[COORD_W-1], vy};
        m_straddle = !seen_zero && ((vy > r_query_y) != (r_prev_y > r_query_y));
    end

    // closing edge runs from the first vertex to the new one
    always_comb begin
        c_dx = {r_query_x[COORD_W-1], r_query_x} - {fx[COORD_W-1], fx};
        c_d  = {vy[COORD_W-1], vy} - {fy[COORD_W-1], fy};
        c_ex = {vx[COORD_W-1], vx} - {fx[COORD_W-1], fx};
        c_ey = {r_query_y[COORD_W-1], r_query_y} - {fy[COORD_W-1], fy};
        c_straddle = i_last_vertex && ((fy > r_query_y) != (vy > r_query_y));
    end

    // queue record
    always_comb begin
        o_ctl.first = seen_zero;
        o_ctl.last  = i_last_vertex;
        o_ctl.count = count_inc;
        o_main      = {m_straddle, m_dx, m_d, m_ex, m_ey};
        o_close     = {c_straddle, c_dx, c_d, c_ex, c_ey};
    end

    // query point registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_x <= '0;
            r_query_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_QUERY_X: r_query_x <= $signed(i_cfg_data);
                REG_QUERY_Y: r_query_y <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // vertex counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (accept) begin
            r_seen <= n_seen;
        end
    end

    // first and previous vertex
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_x <= vx;
            r_prev_y <= vy;
            if (seen_zero) begin
                r_first_x <= vx;
                r_first_y <= vy;
            end
        end
    end

endmodule

>>> rtl/pipc_queue.sv
// pipc_queue: small register fifo between the front and back parts
// depends on pipc_pkg for the default depth

module pipc_queue
    import pipc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/pipc_back.sv
// pipc_back: cross-multiply, compare, parity update and result register
// depends on pipc_pkg; consumes records from pipc_queue

module pipc_back
    import pipc_pkg::*;
#(
    parameter int COORD_W = COORD_W_DEF,
    parameter int EDGE_W  = 4 * (COORD_W + 1) + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // queue side
    input  logic               i_q_empty,
    output logic               o_pop,
    input  t_ctl               i_ctl,
    input  logic [EDGE_W-1:0]  i_main,
    input  logic [EDGE_W-1:0]  i_close,
    // result transaction
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_inside_res,
    output logic [COUNT_W-1:0] o_vertex_count
);

    localparam int OP_W   = COORD_W + 1;
    localparam int PROD_W = 2 * OP_W;

    logic                     advance;

    // unpacked edge operands
    logic                     m_straddle, c_straddle;
    logic signed [OP_W-1:0]   m_dx, m_d, m_ex, m_ey;
    logic signed [OP_W-1:0]   c_dx, c_d, c_ex, c_ey;
    logic signed [PROD_W-1:0] m_p1, m_p2, c_p1, c_p2;

    // product stage
    logic                     r_s1_valid;
    t_ctl                     r_s1_ctl;
    logic                     r_m_straddle, r_c_straddle;
    logic                     r_m_dneg, r_c_dneg;
    logic signed [PROD_W-1:0] r_m_p1, r_m_p2, r_c_p1, r_c_p2;

    // compare stage
    logic                     m_toggle, c_toggle;
    logic                     base_parity;
    logic                     new_parity;
    logic                     r_parity;
    logic                     r_out_valid;
    logic                     r_inside;
    logic [COUNT_W-1:0]       r_count;

    assign advance = !r_out_valid || i_out_ready;
    assign o_pop   = advance && !i_q_empty;

    // split the records
    always_comb begin
        m_straddle = i_main[4*OP_W];
        m_dx       = $signed(i_main[4*OP_W-1:3*OP_W]);
        m_d        = $signed(i_main[3*OP_W-1:2*OP_W]);
        m_ex       = $signed(i_main[2*OP_W-1:OP_W]);
        m_ey       = $signed(i_main[OP_W-1:0]);
        c_straddle = i_close[4*OP_W];
        c_dx       = $signed(i_close[4*OP_W-1:3*OP_W]);
        c_d        = $signed(i_close[3*OP_W-1:2*OP_W]);
        c_ex       = $signed(i_close[2*OP_W-1:OP_W]);
        c_ey       = $signed(i_close[OP_W-1:0]);
    end

    // cross products (px-ax)*(by-ay) and (bx-ax)*(py-ay)
    always_comb begin
        m_p1 = m_dx * m_d;
        m_p2 = m_ex * m_ey;
        c_p1 = c_dx * c_d;
        c_p2 = c_ex * c_ey;
    end

    // product registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_ctl     <= i_ctl;
            r_m_straddle <= m_straddle;
            r_c_straddle <= c_straddle;
            r_m_dneg     <= m_d[OP_W-1];
            r_c_dneg     <= c_d[OP_W-1];
            r_m_p1       <= m_p1;
            r_m_p2       <= m_p2;
            r_c_p1       <= c_p1;
            r_c_p2       <= c_p2;
        end
    end

    // crossing decision; comparison flips when the edge runs downward
    always_comb begin
        m_toggle    = r_m_straddle && (r_m_dneg ? (r_m_p1 > r_m_p2) : (r_m_p1 < r_m_p2));
        c_toggle    = r_c_straddle && (r_c_dneg ? (r_c_p1 > r_c_p2) : (r_c_p1 < r_c_p2));
        base_parity = r_s1_ctl.first ? 1'b0 : r_parity;
        new_parity  = base_parity ^ m_toggle ^ c_toggle;
    end

    // parity and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid && r_s1_ctl.last;
            if (r_s1_valid) begin
                r_parity <= r_s1_ctl.last ? 1'b0 : new_parity;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid && r_s1_ctl.last) begin
            r_inside <= new_parity;
            r_count  <= r_s1_ctl.count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_inside_res   = r_inside;
    assign o_vertex_count = r_count;

endmodule

>>> rtl/point_in_polygon_crossing_top.sv
// point_in_polygon_crossing_top: even-odd point-in-polygon test, streamed vertices
// depends on pipc_pkg, pipc_front, pipc_queue and pipc_back
//
// Usage: write the query point through the config port (index 0 = x, index 1 = y)
// while the block is idle. Stream polygon vertices on the input channel, one
// transaction per vertex, with last_vertex set on the closing vertex. Each
// closing vertex yields one result transaction: inside_res (even-odd rule) and
// vertex_count (saturates at 65535). Other vertices yield nothing.
// Throughput: one vertex per cycle while the receiver takes results. The front
// accepts a vertex whenever the two-entry queue has room; the back takes one
// record a cycle, unless the output stalls, through a product register and a
// compare/parity register that doubles as the output register. A closing
// vertex is written into the queue, then into the product register, and the
// compare loads the output register. When the receiver stalls the back holds,
// the queue fills, and in_ready drops once it is full; nothing is lost.
// Reset (synchronous, active low) clears the query point to the origin, the
// vertex counter, parity, queue and result valid; the next vertex starts a new
// polygon.

module point_in_polygon_crossing_top
    import pipc_pkg::*;
#(
    parameter int COORD_W = COORD_W_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [COORD_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [COORD_W-1:0] i_vertex_x,
    input  logic [COORD_W-1:0] i_vertex_y,
    input  logic               i_last_vertex,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_inside_res,
    output logic [COUNT_W-1:0] o_vertex_count
);

    localparam int EDGE_W  = 4 * (COORD_W + 1) + 1;
    localparam int CTL_W   = $bits(t_ctl);
    localparam int ENTRY_W = CTL_W + 2 * EDGE_W;

    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    t_ctl               f_ctl;
    logic [EDGE_W-1:0]  f_main;
    logic [EDGE_W-1:0]  f_close;
    logic [ENTRY_W-1:0] q_din;
    logic [ENTRY_W-1:0] q_dout;
    t_ctl               b_ctl;
    logic [EDGE_W-1:0]  b_main;
    logic [EDGE_W-1:0]  b_close;

    // front: config, vertex tracking, edge operands
    pipc_front #(
        .COORD_W (COORD_W),
        .EDGE_W  (EDGE_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_last_vertex (i_last_vertex),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_ctl         (f_ctl),
        .o_main        (f_main),
        .o_close       (f_close)
    );

    // record packing around the queue
    assign q_din = {f_ctl, f_main, f_close};
    always_comb begin
        b_ctl   = t_ctl'(q_dout[ENTRY_W-1:2*EDGE_W]);
        b_main  = q_dout[2*EDGE_W-1:EDGE_W];
        b_close = q_dout[EDGE_W-1:0];
    end

    pipc_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_din),
        .i_pop   (q_pop),
        .o_data  (q_dout),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: products, crossing test, parity, result
    pipc_back #(
        .COORD_W (COORD_W),
        .EDGE_W  (EDGE_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .o_pop          (q_pop),
        .i_ctl          (b_ctl),
        .i_main         (b_main),
        .i_close        (b_close),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_inside_res   (o_inside_res),
        .o_vertex_count (o_vertex_count)
    );

    // queue cannot report full and empty at once
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && q_empty))
        else $error("queue full and empty together");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_out_valid)
        else $error("result valid after reset");

    // every result counts at least its closing vertex
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_vertex_count != '0))
        else $error("result with zero vertex count");

    // a record popped while the output stalls would be lost
    a_pop_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !q_pop)
        else $error("queue popped during output stall");

endmodule
